@@ src/tmps_pkg.sv @@
package tmps_pkg;

  localparam int VAL_W        = 16;
  localparam int SUM_W        = 22;
  localparam int CFG_W        = 7;
  localparam int MAX_ROWS_DEF = 64;
  localparam int OQ_DEPTH     = 3;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 7'd64;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 22'sh1FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -22'sh200000;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
    logic signed [SUM_W:0] hi;
    logic signed [SUM_W:0] lo;
    hi = {SUM_MAX[SUM_W-1], SUM_MAX};
    lo = {SUM_MIN[SUM_W-1], SUM_MIN};
    if (x > hi) begin
      return SUM_MAX;
    end else if (x < lo) begin
      return SUM_MIN;
    end
    return x[SUM_W-1:0];
  endfunction

endpackage

@@ src/triangle_max_path_sum_top.sv @@
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_entry_value
// out_    | output    | out_valid/out_stall| out_cell_sum, out_is_final, out_best_sum
// cfg_    | input     | cfg_wr_en          | cfg_wr_data (row_count)
//
// One entry per cycle while in_stall is low; a word passes the stage register, then the output queue.
// The row store is read at acceptance and written back in the next cycle; a
// back-to-back read of the entry being written takes the forwarded sum.
// Reset clears counters, state and queue pointers; the row store needs no clearing pass.
// A 3-word output queue absorbs out_stall; in_stall rises when it may fill.
module triangle_max_path_sum_top #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tmps_pkg::VAL_W-1:0]    in_entry_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tmps_pkg::SUM_W-1:0]    out_cell_sum,
  output logic                                 out_is_final,
  output logic signed [tmps_pkg::SUM_W-1:0]    out_best_sum,
  input  logic                                 cfg_wr_en,
  input  logic        [tmps_pkg::CFG_W-1:0]    cfg_wr_data
);
  import tmps_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam logic [CW-1:0] MaxRowsC = CW'(MAX_ROWS);
  localparam logic [RW-1:0] LastRowC = RW'(MAX_ROWS - 1);

  typedef struct packed {
    logic [RW-1:0]           col;
    logic                    row_zero;
    logic                    col_zero;
    logic                    col_last;
    logic                    last_row;
    logic                    final_e;
    logic signed [VAL_W-1:0] value;
  } stage_t;

  // registers
  logic [CFG_W-1:0]        row_count_r;
  logic [RW-1:0]           row_r, row_nxt;
  logic [RW-1:0]           col_r, col_nxt;
  stage_t                  sb_r, sb_nxt;
  logic                    sb_vld_r;
  logic                    fwd_r, fwd_nxt;
  logic signed [SUM_W-1:0] fwd_sum_r;
  logic signed [SUM_W-1:0] mem_q_r;
  logic signed [SUM_W-1:0] held_r;
  logic signed [SUM_W-1:0] best_r, best_nxt;
  logic [1:0]              wp_r, rp_r, cnt_r;

  logic signed [SUM_W-1:0] row_mem [MAX_ROWS];
  logic signed [SUM_W-1:0] oq_sum  [OQ_DEPTH];
  logic                    oq_fin  [OQ_DEPTH];
  logic signed [SUM_W-1:0] oq_best [OQ_DEPTH];

  // accept side
  logic          in_acc;
  logic [CW-1:0] rows_ext, rows_eff;
  logic [RW-1:0] r_cl, c_cl;
  logic          last_row, col_last, final_e;

  assign in_stall = ({1'b0, cnt_r} + {2'b00, sb_vld_r}) >= 3'(OQ_DEPTH);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    rows_ext = CW'(row_count_r);
    if (rows_ext == '0) begin
      rows_eff = CW'(1);
    end else if (rows_ext > MaxRowsC) begin
      rows_eff = MaxRowsC;
    end else begin
      rows_eff = rows_ext;
    end
    r_cl     = (CW'(row_r) >= MaxRowsC) ? LastRowC : row_r;
    c_cl     = (col_r > r_cl) ? r_cl : col_r;
    last_row = (CW'(r_cl) + CW'(1)) >= rows_eff;
    col_last = (c_cl == r_cl);
    final_e  = last_row && col_last;

    row_nxt = row_r;
    col_nxt = col_r;
    if (in_acc) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = final_e ? '0 : r_cl + RW'(1);
      end else begin
        col_nxt = c_cl + RW'(1);
        row_nxt = r_cl;
      end
    end

    sb_nxt.col      = c_cl;
    sb_nxt.row_zero = (r_cl == '0);
    sb_nxt.col_zero = (c_cl == '0);
    sb_nxt.col_last = col_last;
    sb_nxt.last_row = last_row;
    sb_nxt.final_e  = final_e;
    sb_nxt.value    = in_entry_value;
  end

  // compute side
  logic signed [SUM_W-1:0] old_here, parent, sum_b;
  logic                    push, pop;

  assign old_here = fwd_r ? fwd_sum_r : mem_q_r;
  assign push     = sb_vld_r;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    if (sb_r.row_zero) begin
      parent = '0;
    end else if (sb_r.col_zero) begin
      parent = old_here;
    end else if (sb_r.col_last) begin
      parent = held_r;
    end else begin
      parent = (held_r > old_here) ? held_r : old_here;
    end
    sum_b = sat_sum({{(SUM_W + 1 - VAL_W){sb_r.value[VAL_W-1]}}, sb_r.value} +
                    {parent[SUM_W-1], parent});

    best_nxt = best_r;
    if (sb_vld_r && sb_r.last_row && (sb_r.col_zero || sum_b > best_r)) begin
      best_nxt = sum_b;
    end

    fwd_nxt = in_acc && sb_vld_r && (sb_r.col == c_cl);
  end

  always_ff @(posedge clk) begin
    if (sb_vld_r) begin
      row_mem[sb_r.col] <= sum_b;
    end
    if (in_acc) begin
      mem_q_r <= row_mem[c_cl];
      sb_r    <= sb_nxt;
    end
    fwd_sum_r <= sum_b;
    if (push) begin
      oq_sum[wp_r]  <= sum_b;
      oq_fin[wp_r]  <= sb_r.final_e;
      oq_best[wp_r] <= sb_r.final_e ? best_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      row_r       <= '0;
      col_r       <= '0;
      sb_vld_r    <= 1'b0;
      fwd_r       <= 1'b0;
      held_r      <= '0;
      best_r      <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_count_r <= cfg_wr_data;
      end
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      sb_vld_r <= in_acc;
      fwd_r    <= fwd_nxt;
      if (sb_vld_r) begin
        held_r <= old_here;
      end
      best_r <= best_nxt;
      if (push) begin
        wp_r <= (wp_r == 2'(OQ_DEPTH - 1)) ? 2'd0 : wp_r + 2'd1;
      end
      if (pop) begin
        rp_r <= (rp_r == 2'(OQ_DEPTH - 1)) ? 2'd0 : rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid    = (cnt_r != 2'd0);
  assign out_cell_sum = oq_sum[rp_r];
  assign out_is_final = oq_fin[rp_r];
  assign out_best_sum = oq_best[rp_r];

  // checks
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(OQ_DEPTH))
    else $error("output queue over depth");

  a_fwd_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && sb_vld_r && sb_r.col == c_cl) |=> fwd_r)
    else $error("missing forward on row store hazard");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> sb_vld_r)
    else $error("forward flag without item in flight");

  a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_final) |-> (out_best_sum == '0))
    else $error("best_sum nonzero on non-final word");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(OQ_DEPTH)) |-> in_stall)
    else $error("input taken with full output queue");

endmodule
